[rtl/sfcs_pkg.sv]
// Shared types, constants and fixed-point helpers for the frame class scorer.
`timescale 1ns / 1ps

package sfcs_pkg;

	localparam int NUM_CLASSES = 13;
	localparam int CLASS_W     = 4;
	localparam int SCORE_W     = 16;

	localparam logic [CLASS_W-1:0] CLASS_SILENCE = 4'd0;
	localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 4'd12;

	localparam logic [15:0] THRESHOLD_RESET = 16'd1802;

	// Q1.15 constants
	localparam logic [15:0] Q_ONE  = 16'd32768;
	localparam logic [15:0] Q0_025 = 16'd819;
	localparam logic [15:0] Q0_05  = 16'd1638;
	localparam logic [15:0] Q0_12  = 16'd3932;
	localparam logic [15:0] Q0_16  = 16'd5243;
	localparam logic [15:0] Q0_18  = 16'd5898;
	localparam logic [15:0] Q0_20  = 16'd6554;
	localparam logic [15:0] Q0_22  = 16'd7209;
	localparam logic [15:0] Q0_25  = 16'd8192;
	localparam logic [15:0] Q0_30  = 16'd9830;
	localparam logic [15:0] Q0_32  = 16'd10486;
	localparam logic [15:0] Q0_34  = 16'd11141;
	localparam logic [15:0] Q0_35  = 16'd11469;
	localparam logic [15:0] Q0_45  = 16'd14746;
	localparam logic [15:0] Q0_48  = 16'd15729;
	localparam logic [15:0] Q0_52  = 16'd17039;
	localparam logic [15:0] Q0_55  = 16'd18022;
	localparam logic [15:0] Q0_56  = 16'd18350;
	localparam logic [15:0] Q0_65  = 16'd21299;
	localparam logic [15:0] Q0_72  = 16'd23593;
	localparam logic [15:0] Q0_75  = 16'd24576;
	localparam logic [15:0] Q0_78  = 16'd25559;
	localparam logic [15:0] Q0_85  = 16'd27853;
	localparam logic [15:0] Q1_15  = 16'd37683;

	// Low-RMS smoothstep: t = (T_KNEE - rms) * 32768 / T_KNEE, rounded.
	localparam logic [12:0] T_KNEE   = 13'd5898;
	localparam logic [27:0] T_ROUND  = 28'd2949;
	localparam logic [27:0] T_RECIP  = 28'd186421096; // floor(2^40 / 5898)
	localparam int          T_SHIFT  = 40;
	localparam logic [17:0] Q_THREE  = 18'd98304;

	typedef logic signed [23:0] sum_t;
	typedef logic [NUM_CLASSES-1:0][SCORE_W-1:0] score_arr_t;

	typedef struct packed {
		logic [15:0]        rms_level;
		logic [15:0]        spectral_flux;
		logic [15:0]        periodicity;
		logic [15:0]        high_band_level;
		logic [15:0]        zero_cross_rate;
		logic [15:0]        centroid_level;
		logic               flux_peak_flag;
		logic signed [16:0] rms_delta;
		logic [15:0]        low_band_level;
		logic [15:0]        mid_band_level;
		logic               rms_valley_flag;
	} frame_in_t;

	typedef struct packed {
		score_arr_t scores;
		logic       is_speech;
	} frame_out_t;

	// Product with a Q1.15 weight, rounded to nearest (nonnegative operands).
	function automatic logic [20:0] qmul_u(input logic [17:0] a, input logic [17:0] w);
		logic [35:0] p;
		p = 36'(a) * 36'(w) + 36'd16384;
		return p[35:15];
	endfunction

	function automatic sum_t to_sum(input logic [20:0] v);
		return sum_t'({3'b000, v});
	endfunction

	function automatic sum_t qm(input logic [15:0] a, input logic [15:0] w);
		return to_sum(qmul_u({2'b00, a}, {2'b00, w}));
	endfunction

	// Signed operand: round the magnitude, ties away from zero.
	function automatic sum_t qm_s(input logic signed [17:0] a, input logic [15:0] w);
		logic [17:0] mag;
		sum_t        r;
		mag = a[17] ? 18'(-a) : 18'(a);
		r   = to_sum(qmul_u(mag, {2'b00, w}));
		return a[17] ? -r : r;
	endfunction

	function automatic logic [15:0] qsat(input sum_t x);
		if (x < 0) begin
			return 16'd0;
		end else if (x > sum_t'(Q_ONE)) begin
			return Q_ONE;
		end
		return x[15:0];
	endfunction

	function automatic logic [15:0] level_clamp(input logic [15:0] v);
		return (v > Q_ONE) ? Q_ONE : v;
	endfunction

endpackage

[rtl/sfcs_score_pipe.sv]
// Six-stage score pipeline: one frame in, all thirteen class scores out.
`timescale 1ns / 1ps

module sfcs_score_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfcs_pkg::frame_in_t in_frame,
	input  logic [15:0]         threshold,
	output logic                out_valid,
	input  logic                out_ready,
	output sfcs_pkg::frame_out_t out_frame
);

	typedef struct packed {
		logic [15:0]        rms;
		logic [15:0]        flux;
		logic [15:0]        per;
		logic [15:0]        hi;
		logic [15:0]        zcr;
		logic [15:0]        cen;
		logic [15:0]        lo;
		logic [15:0]        mid;
		logic signed [16:0] drms;
		logic               fpeak;
		logic               vflag;
		logic               tpos;
		logic [12:0]        num;
	} st1_t;

	typedef struct packed {
		logic [15:0] speech;
		logic [15:0] voiced;
		logic [15:0] fric;
		logic [15:0] burst;
		logic [15:0] lowc;
		logic [15:0] lowh;
		logic [15:0] rms;
		logic [15:0] flux;
		logic [15:0] hi;
		logic [15:0] zcr;
		logic [15:0] cen;
		logic [15:0] lo;
		logic [15:0] mid;
		logic        rms_low;
		logic        vflag;
		logic        tpos;
		logic [15:0] f1;
		logic [15:0] f2;
		logic [15:0] f3;
		logic [27:0] x;
		logic [15:0] q0;
	} st2_t;

	// Shared by stages 3..6; tw holds t, then t*t, then the smoothstep.
	typedef struct packed {
		sfcs_pkg::score_arr_t sc;
		logic                 is_speech;
		logic [15:0]          vbase;
		logic [15:0]          f1;
		logic [15:0]          f2;
		logic [15:0]          f3;
		logic [15:0]          part4;
		logic [15:0]          tw;
		logic [17:0]          w;
		logic                 vflag;
	} st3_t;

	st1_t d_s1;
	st2_t d_s2;
	st3_t d_s3, d_s4, d_s5, d_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic r1, r2, r3, r4, r5, r6;

	st1_t n1;
	st2_t n2;
	st3_t n3, n4, n5, n6;

	assign r6 = !v_s6 || out_ready;
	assign r5 = !v_s5 || r6;
	assign r4 = !v_s4 || r5;
	assign r3 = !v_s3 || r4;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign in_ready = r1;

	// Stage 1: clamp inputs, smoothstep numerator.
	always_comb begin
		n1.rms   = sfcs_pkg::level_clamp(in_frame.rms_level);
		n1.flux  = sfcs_pkg::level_clamp(in_frame.spectral_flux);
		n1.per   = sfcs_pkg::level_clamp(in_frame.periodicity);
		n1.hi    = sfcs_pkg::level_clamp(in_frame.high_band_level);
		n1.zcr   = sfcs_pkg::level_clamp(in_frame.zero_cross_rate);
		n1.cen   = sfcs_pkg::level_clamp(in_frame.centroid_level);
		n1.lo    = sfcs_pkg::level_clamp(in_frame.low_band_level);
		n1.mid   = sfcs_pkg::level_clamp(in_frame.mid_band_level);
		if (in_frame.rms_delta > 17'sd32768) begin
			n1.drms = 17'sd32768;
		end else if (in_frame.rms_delta < -17'sd32768) begin
			n1.drms = -17'sd32768;
		end else begin
			n1.drms = in_frame.rms_delta;
		end
		n1.fpeak = in_frame.flux_peak_flag;
		n1.vflag = in_frame.rms_valley_flag;
		n1.tpos  = (n1.rms < 16'(sfcs_pkg::T_KNEE));
		n1.num   = sfcs_pkg::T_KNEE - n1.rms[12:0];
	end

	// Stage 2: derived features, vowel factors, reciprocal estimate of t.
	always_comb begin
		sfcs_pkg::sum_t a, b, m;
		logic [55:0]    pr;
		a = sfcs_pkg::qm(d_s1.flux, sfcs_pkg::Q0_55);
		b = sfcs_pkg::qm(d_s1.per, sfcs_pkg::Q0_45);
		m = (a > b) ? a : b;
		m = (m > sfcs_pkg::sum_t'(d_s1.rms)) ? m : sfcs_pkg::sum_t'(d_s1.rms);
		n2.speech = sfcs_pkg::qsat(m);
		n2.voiced = sfcs_pkg::qsat(sfcs_pkg::qm(d_s1.per, sfcs_pkg::Q1_15)
			+ sfcs_pkg::qm(d_s1.rms, sfcs_pkg::Q0_35) - sfcs_pkg::qm(d_s1.flux, sfcs_pkg::Q0_18));
		n2.fric = sfcs_pkg::qsat(sfcs_pkg::qm(d_s1.hi, sfcs_pkg::Q0_65)
			+ sfcs_pkg::qm(d_s1.zcr, sfcs_pkg::Q0_55) + sfcs_pkg::qm(d_s1.cen, sfcs_pkg::Q0_45)
			+ sfcs_pkg::qm(d_s1.flux, sfcs_pkg::Q0_25));
		n2.burst = sfcs_pkg::qsat(sfcs_pkg::qm(d_s1.flux, sfcs_pkg::Q0_75)
			+ (d_s1.fpeak ? sfcs_pkg::sum_t'(sfcs_pkg::Q0_30) : sfcs_pkg::sum_t'(0))
			+ sfcs_pkg::qm_s(18'(d_s1.drms), sfcs_pkg::Q0_25));
		n2.lowc    = sfcs_pkg::Q_ONE - d_s1.cen;
		n2.lowh    = sfcs_pkg::Q_ONE - d_s1.hi;
		n2.rms     = d_s1.rms;
		n2.flux    = d_s1.flux;
		n2.hi      = d_s1.hi;
		n2.zcr     = d_s1.zcr;
		n2.cen     = d_s1.cen;
		n2.lo      = d_s1.lo;
		n2.mid     = d_s1.mid;
		n2.rms_low = (d_s1.rms < sfcs_pkg::Q0_025);
		n2.vflag   = d_s1.vflag;
		n2.tpos    = d_s1.tpos;
		n2.f1 = 16'(sfcs_pkg::sum_t'(sfcs_pkg::Q0_65) + sfcs_pkg::qm(d_s1.lo, sfcs_pkg::Q0_30)
			+ sfcs_pkg::qm(d_s1.mid, sfcs_pkg::Q0_20));
		n2.f2 = 16'(sfcs_pkg::sum_t'(sfcs_pkg::Q0_52) + sfcs_pkg::qm(d_s1.mid, sfcs_pkg::Q0_32)
			+ sfcs_pkg::qm(d_s1.cen, sfcs_pkg::Q0_22));
		n2.f3 = 16'(sfcs_pkg::sum_t'(sfcs_pkg::Q0_56) + sfcs_pkg::qm(n2.lowc, sfcs_pkg::Q0_34)
			+ sfcs_pkg::qm(d_s1.lo, sfcs_pkg::Q0_20));
		n2.x  = {d_s1.num, 15'd0} + sfcs_pkg::T_ROUND;
		pr    = 56'(n2.x) * 56'(sfcs_pkg::T_RECIP);
		// estimate is the quotient or one below it
		n2.q0 = pr[sfcs_pkg::T_SHIFT +: 16];
	end

	// Stage 3: vowel base, most class scores, speech flag, quotient fix-up.
	always_comb begin
		logic [28:0] qd, rem;
		logic [16:0] tq;
		n3.sc = '0;
		n3.sc[0] = sfcs_pkg::qsat(sfcs_pkg::qm(sfcs_pkg::Q_ONE - d_s2.speech, sfcs_pkg::Q0_85)
			+ (d_s2.rms_low ? sfcs_pkg::sum_t'(sfcs_pkg::Q0_25) : sfcs_pkg::sum_t'(0)));
		n3.sc[5] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s2.fric, sfcs_pkg::Q0_55)
			+ sfcs_pkg::qm(d_s2.mid, sfcs_pkg::Q0_25) + sfcs_pkg::qm(d_s2.lowc, sfcs_pkg::Q0_18)
			- sfcs_pkg::qm(d_s2.hi, sfcs_pkg::Q0_12));
		n3.sc[6] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s2.fric, sfcs_pkg::Q0_45)
			+ sfcs_pkg::qm(d_s2.mid, sfcs_pkg::Q0_22) + sfcs_pkg::qm(d_s2.zcr, sfcs_pkg::Q0_20));
		n3.sc[7] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s2.fric, sfcs_pkg::Q0_78)
			+ sfcs_pkg::qm(d_s2.hi, sfcs_pkg::Q0_32) + sfcs_pkg::qm(d_s2.cen, sfcs_pkg::Q0_30));
		n3.sc[8] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s2.burst, sfcs_pkg::Q0_78)
			+ sfcs_pkg::qm(d_s2.mid, sfcs_pkg::Q0_18) + sfcs_pkg::qm(d_s2.hi, sfcs_pkg::Q0_12));
		n3.sc[9] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s2.voiced, sfcs_pkg::Q0_52)
			+ sfcs_pkg::qm(d_s2.mid, sfcs_pkg::Q0_22) + sfcs_pkg::qm(d_s2.cen, sfcs_pkg::Q0_16));
		n3.sc[10] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s2.voiced, sfcs_pkg::Q0_48)
			+ sfcs_pkg::qm(d_s2.lowc, sfcs_pkg::Q0_18) + sfcs_pkg::qm(d_s2.mid, sfcs_pkg::Q0_16));
		n3.sc[11] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s2.voiced, sfcs_pkg::Q0_56)
			+ sfcs_pkg::qm(d_s2.lo, sfcs_pkg::Q0_32) + sfcs_pkg::qm(d_s2.lowc, sfcs_pkg::Q0_22)
			- sfcs_pkg::qm(d_s2.hi, sfcs_pkg::Q0_16));
		n3.sc[12] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s2.speech, sfcs_pkg::Q0_35)
			+ sfcs_pkg::sum_t'(sfcs_pkg::Q0_05));
		n3.is_speech = (d_s2.speech >= threshold);
		n3.vbase = sfcs_pkg::qsat(sfcs_pkg::qm(d_s2.voiced, sfcs_pkg::Q0_72)
			+ sfcs_pkg::qm(d_s2.rms, sfcs_pkg::Q0_45) + sfcs_pkg::qm(d_s2.lowh, sfcs_pkg::Q0_20)
			- sfcs_pkg::qm(d_s2.flux, sfcs_pkg::Q0_20));
		n3.f1    = d_s2.f1;
		n3.f2    = d_s2.f2;
		n3.f3    = d_s2.f3;
		n3.part4 = 16'(sfcs_pkg::qm(d_s2.burst, sfcs_pkg::Q0_32)
			+ sfcs_pkg::qm(d_s2.lowc, sfcs_pkg::Q0_18));
		qd  = 29'(d_s2.q0) * 29'(sfcs_pkg::T_KNEE);
		rem = 29'(d_s2.x) - qd;
		tq  = (rem >= 29'(sfcs_pkg::T_KNEE)) ? 17'(d_s2.q0) + 17'd1 : 17'(d_s2.q0);
		if (!d_s2.tpos) begin
			n3.tw = 16'd0;
		end else if (tq > 17'(sfcs_pkg::Q_ONE)) begin
			n3.tw = sfcs_pkg::Q_ONE;
		end else begin
			n3.tw = tq[15:0];
		end
		n3.w     = 18'd0;
		n3.vflag = d_s2.vflag;
	end

	// Stage 4: vowel scores, t squared, cubic weight.
	always_comb begin
		logic [20:0] tt;
		n4 = d_s3;
		n4.sc[1] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s3.vbase, d_s3.f1));
		n4.sc[2] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s3.vbase, d_s3.f2));
		n4.sc[3] = sfcs_pkg::qsat(sfcs_pkg::qm(d_s3.vbase, d_s3.f3));
		tt    = sfcs_pkg::qmul_u({2'b00, d_s3.tw}, {2'b00, d_s3.tw});
		n4.tw = tt[15:0];
		n4.w  = sfcs_pkg::Q_THREE - {1'b0, d_s3.tw, 1'b0};
	end

	// Stage 5: smoothstep.
	always_comb begin
		logic [20:0] sm;
		n5    = d_s4;
		sm    = sfcs_pkg::qmul_u({2'b00, d_s4.tw}, d_s4.w);
		n5.tw = sm[15:0];
	end

	// Stage 6: bilabial score from the valley term.
	always_comb begin
		sfcs_pkg::sum_t valley;
		n6 = d_s5;
		valley = (d_s5.vflag ? sfcs_pkg::sum_t'(sfcs_pkg::Q0_45) : sfcs_pkg::sum_t'(0))
			+ sfcs_pkg::qm(d_s5.tw, sfcs_pkg::Q0_35);
		n6.sc[4] = sfcs_pkg::qsat(valley + sfcs_pkg::sum_t'(d_s5.part4));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
			if (r5) v_s5 <= v_s4;
			if (r6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && in_valid) d_s1 <= n1;
		if (r2 && v_s1)     d_s2 <= n2;
		if (r3 && v_s2)     d_s3 <= n3;
		if (r4 && v_s3)     d_s4 <= n4;
		if (r5 && v_s4)     d_s5 <= n5;
		if (r6 && v_s5)     d_s6 <= n6;
	end

	assign out_valid           = v_s6;
	assign out_frame.scores    = d_s6.sc;
	assign out_frame.is_speech = d_s6.is_speech;

endmodule

[rtl/speech_frame_class_scorer.sv]
// Top level of the speech frame class scorer: score pipeline and result sequencer.
`timescale 1ns / 1ps

// Usage
//   s_axis_*: one audio feature frame per request. The two peak/valley flags
//     ride on s_axis_tuser, all level fields and the RMS delta on s_axis_tdata.
//   m_axis_*: thirteen results per frame, one per request, class 0 (silence)
//     up to class 12 (unknown). tlast marks class 12; tuser carries the frame's
//     speech flag, identical on all thirteen results.
//   cfg_*: writes the speech threshold (Q1.15). cfg_ready is always high;
//     write it only while no frame is in flight.
// Path: an accepted frame is loaded into the first of six pipeline stages,
//   moves through them in order, and the sixth stage loads the result
//   register, from which the frame's first result is valid.
// Throughput: one result per cycle when the receiver never stalls, thirteen
//   results per frame; the output sequencer that walks the thirteen scores
//   sets that rate. Up to six more frames queue in the pipeline meanwhile.
// Reset: arst_n clears every valid bit and the sequencer and loads the
//   threshold with 1802 (0.055). No clearing pass is needed.
// Stall: when m_axis_tready is low the current result holds; the pipeline
//   keeps filling until every one of its stages is occupied, then
//   s_axis_tready drops. Nothing is dropped or repeated.

module speech_frame_class_scorer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [15:0] rms_level, [31:16] spectral_flux, [47:32] periodicity,
	// [63:48] high_band_level, [79:64] zero_cross_rate, [95:80] centroid_level,
	// [112:96] rms_delta, [128:113] low_band_level, [144:129] mid_band_level,
	// [151:145] zero
	input  logic [151:0] s_axis_tdata,
	// [0] flux_peak_flag, [1] rms_valley_flag
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [3:0] class_id, [19:4] class_score, [23:20] zero
	output logic [23:0]  m_axis_tdata,
	// [0] is_speech
	output logic         m_axis_tuser,
	// last_result
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	sfcs_pkg::frame_in_t  in_frame;
	sfcs_pkg::frame_out_t pipe_frame;
	logic                 pipe_valid;
	logic                 pipe_ready;

	logic [15:0]                       thr_q;
	sfcs_pkg::score_arr_t              shift_q;
	logic [sfcs_pkg::CLASS_W-1:0]      cnt_q;
	logic                              busy_q;
	logic                              speech_q;
	logic                              take;
	logic                              at_last;

	// unpack the request fields
	assign in_frame.rms_level       = s_axis_tdata[15:0];
	assign in_frame.spectral_flux   = s_axis_tdata[31:16];
	assign in_frame.periodicity     = s_axis_tdata[47:32];
	assign in_frame.high_band_level = s_axis_tdata[63:48];
	assign in_frame.zero_cross_rate = s_axis_tdata[79:64];
	assign in_frame.centroid_level  = s_axis_tdata[95:80];
	assign in_frame.rms_delta       = s_axis_tdata[112:96];
	assign in_frame.low_band_level  = s_axis_tdata[128:113];
	assign in_frame.mid_band_level  = s_axis_tdata[144:129];
	assign in_frame.flux_peak_flag  = s_axis_tuser[0];
	assign in_frame.rms_valley_flag = s_axis_tuser[1];

	// threshold register; the port never pushes back
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= sfcs_pkg::THRESHOLD_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	sfcs_score_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_frame  (in_frame),
		.threshold (thr_q),
		.out_valid (pipe_valid),
		.out_ready (pipe_ready),
		.out_frame (pipe_frame)
	);

	// Result sequencer: hold one frame's scores in a shift line and walk them
	// out in class order. The next frame loads in the same cycle that the
	// unknown-class result leaves, so back-to-back frames run without a gap.
	assign take       = m_axis_tvalid && m_axis_tready;
	assign at_last    = (cnt_q == sfcs_pkg::CLASS_UNKNOWN);
	assign pipe_ready = !busy_q || (m_axis_tready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= sfcs_pkg::CLASS_SILENCE;
		end else if (pipe_valid && pipe_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= sfcs_pkg::CLASS_SILENCE;
		end else if (take) begin
			busy_q <= !at_last;
			cnt_q  <= at_last ? sfcs_pkg::CLASS_SILENCE : cnt_q + 4'd1;
		end
	end

	// payload: load a fresh frame, or advance one class per request
	always_ff @(posedge clk) begin
		if (pipe_valid && pipe_ready) begin
			shift_q  <= pipe_frame.scores;
			speech_q <= pipe_frame.is_speech;
		end else if (take) begin
			shift_q <= {16'd0, shift_q[sfcs_pkg::NUM_CLASSES-1:1]};
		end
	end

	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = {4'd0, shift_q[0], cnt_q};
	assign m_axis_tuser  = speech_q;
	assign m_axis_tlast  = at_last;

endmodule

[rtl/sfcs_checker.sv]
// Port-level checks on the result stream of the frame class scorer, bound to the top.
`timescale 1ns / 1ps

module sfcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	logic take;
	assign take = m_axis_tvalid && m_axis_tready;

	// tlast marks the unknown class and nothing else
	a_last_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[3:0] == sfcs_pkg::CLASS_UNKNOWN)))
		else $error("tlast does not match class 12");

	// inside a frame the next class follows at once
	a_class_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !m_axis_tlast |=> m_axis_tvalid
			&& (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1))
		else $error("class sequence broken inside a frame");

	// a new frame opens with silence
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		take && m_axis_tlast |=> !m_axis_tvalid
			|| (m_axis_tdata[3:0] == sfcs_pkg::CLASS_SILENCE))
		else $error("frame does not start at class 0");

	// speech flag is a per-frame value
	a_speech_frame: assert property (@(posedge clk) disable iff (!arst_n)
		take && !m_axis_tlast |=> $stable(m_axis_tuser))
		else $error("speech flag changed inside a frame");

	// saturated score never exceeds one
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[19:4] <= sfcs_pkg::Q_ONE))
		else $error("class score above 1.0");

endmodule

bind speech_frame_class_scorer sfcs_checker u_sfcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

[bench/tb.sv]
// Self-checking bench for the speech frame class scorer: random frames, stalls, score checks.
`timescale 1ns / 1ps

module tb;

	// Phone classes in the order the block emits them.
	typedef enum logic [3:0] {
		CL_SILENCE, CL_OPEN_VOWEL, CL_FRONT_VOWEL, CL_ROUND_VOWEL,
		CL_BILABIAL, CL_LABIODENTAL, CL_DENTAL, CL_SIBILANT,
		CL_STOP_BURST, CL_LIQUID, CL_GLIDE, CL_NASAL, CL_UNKNOWN
	} phone_class_t;

	typedef struct {
		logic [3:0]  class_id;
		logic [15:0] score;
		logic        speech;
		logic        last_flag;
	} class_result_t;

	// Scoreboard: turn each accepted frame into its thirteen class scores,
	// then match the result stream against them in order.
	class score_tracker_t;
		logic [15:0]   threshold;
		class_result_t pending_scores[$];
		int unsigned   faults;

		function new();
			threshold = sfcs_pkg::THRESHOLD_RESET;
			faults    = 0;
		endfunction

		// Product with a Q1.15 weight, rounded to nearest, ties away from zero.
		static function longint wmul(longint a, longint w);
			longint p;
			p = a * w;
			if (p >= 0) begin
				return (p + 16384) / 32768;
			end
			return -((-p + 16384) / 32768);
		endfunction

		static function longint clip_q(longint x);
			if (x < 0) begin
				return 0;
			end else if (x > 32768) begin
				return 32768;
			end
			return x;
		endfunction

		// Clamp a level field to 1.0.
		static function longint lvl(logic [15:0] v);
			return (v > 16'd32768) ? 32768 : longint'(v);
		endfunction

		function void note_frame(sfcs_pkg::frame_in_t f);
			longint rms, flux, per, hi, zcr, cen, lo, mid, drms;
			longint speech, voiced, fric, burst, lowc, lowh, num, t, sm, valley, vbase;
			longint sc[13];
			class_result_t r;

			rms  = lvl(f.rms_level);
			flux = lvl(f.spectral_flux);
			per  = lvl(f.periodicity);
			hi   = lvl(f.high_band_level);
			zcr  = lvl(f.zero_cross_rate);
			cen  = lvl(f.centroid_level);
			lo   = lvl(f.low_band_level);
			mid  = lvl(f.mid_band_level);
			drms = longint'(f.rms_delta);
			if (drms > 32768) drms = 32768;
			if (drms < -32768) drms = -32768;

			// Derived features
			speech = wmul(flux, 18022);
			if (wmul(per, 14746) > speech) speech = wmul(per, 14746);
			if (rms > speech) speech = rms;
			speech = clip_q(speech);
			voiced = clip_q(wmul(per, 37683) + wmul(rms, 11469) - wmul(flux, 5898));
			fric   = clip_q(wmul(hi, 21299) + wmul(zcr, 18022) + wmul(cen, 14746)
				+ wmul(flux, 8192));
			burst  = clip_q(wmul(flux, 24576) + (f.flux_peak_flag ? 9830 : 0)
				+ wmul(drms, 8192));
			lowc   = 32768 - cen;
			lowh   = 32768 - hi;

			// Smoothstep that rises as RMS falls below the 0.18 knee
			num = 5898 - rms;
			if (num <= 0) begin
				t = 0;
			end else begin
				t = (num * 32768 + 2949) / 5898;
				if (t > 32768) t = 32768;
			end
			sm     = wmul(wmul(t, t), 98304 - 2 * t);
			valley = (f.rms_valley_flag ? 14746 : 0) + wmul(sm, 11469);

			sc[CL_SILENCE] = clip_q(wmul(32768 - speech, 27853) + (rms < 819 ? 8192 : 0));

			// Vowel factors stay unsaturated until the final product
			vbase = clip_q(wmul(voiced, 23593) + wmul(rms, 14746) + wmul(lowh, 6554)
				- wmul(flux, 6554));
			sc[CL_OPEN_VOWEL]  = clip_q(wmul(vbase, 21299 + wmul(lo, 9830) + wmul(mid, 6554)));
			sc[CL_FRONT_VOWEL] = clip_q(wmul(vbase, 17039 + wmul(mid, 10486) + wmul(cen, 7209)));
			sc[CL_ROUND_VOWEL] = clip_q(wmul(vbase, 18350 + wmul(lowc, 11141) + wmul(lo, 6554)));

			sc[CL_BILABIAL]    = clip_q(valley + wmul(burst, 10486) + wmul(lowc, 5898));
			sc[CL_LABIODENTAL] = clip_q(wmul(fric, 18022) + wmul(mid, 8192) + wmul(lowc, 5898)
				- wmul(hi, 3932));
			sc[CL_DENTAL]      = clip_q(wmul(fric, 14746) + wmul(mid, 7209) + wmul(zcr, 6554));
			sc[CL_SIBILANT]    = clip_q(wmul(fric, 25559) + wmul(hi, 10486) + wmul(cen, 9830));
			sc[CL_STOP_BURST]  = clip_q(wmul(burst, 25559) + wmul(mid, 5898) + wmul(hi, 3932));
			sc[CL_LIQUID]      = clip_q(wmul(voiced, 17039) + wmul(mid, 7209) + wmul(cen, 5243));
			sc[CL_GLIDE]       = clip_q(wmul(voiced, 15729) + wmul(lowc, 5898) + wmul(mid, 5243));
			sc[CL_NASAL]       = clip_q(wmul(voiced, 18350) + wmul(lo, 10486) + wmul(lowc, 7209)
				- wmul(hi, 5243));
			sc[CL_UNKNOWN]     = clip_q(wmul(speech, 11469) + 1638);

			for (int k = 0; k < 13; k++) begin
				r.class_id  = 4'(k);
				r.score     = 16'(sc[k]);
				r.speech    = (speech >= longint'(threshold));
				r.last_flag = (k == CL_UNKNOWN);
				pending_scores.push_back(r);
			end
		endfunction

		function void check_result(logic [3:0] class_id, logic [15:0] score,
			logic speech, logic last_flag);
			class_result_t want;
			if (pending_scores.size() == 0) begin
				$error("unexpected result: class_id %0d, class_score %0d", class_id, score);
				faults++;
				return;
			end
			want = pending_scores.pop_front();
			if (class_id !== want.class_id) begin
				$error("class_id: expected %0d, got %0d", want.class_id, class_id);
				faults++;
			end
			if (score !== want.score) begin
				$error("class_score (class %0d): expected %0d, got %0d",
					want.class_id, want.score, score);
				faults++;
			end
			if (speech !== want.speech) begin
				$error("is_speech (class %0d): expected %0d, got %0d",
					want.class_id, want.speech, speech);
				faults++;
			end
			if (last_flag !== want.last_flag) begin
				$error("last_result (class %0d): expected %0d, got %0d",
					want.class_id, want.last_flag, last_flag);
				faults++;
			end
		endfunction

		function int pending();
			return pending_scores.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [151:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [23:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	score_tracker_t tracker;
	int             results_seen = 0;

	speech_frame_class_scorer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every accepted result request against the oldest expected score.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			tracker.check_result(m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tuser,
				m_axis_tlast);
		end
	end

	// Receiver: stall about 12% of cycles. Once, early on, hold off for a long
	// stretch so the pipeline fills and the input stalls; later keep a window
	// with no stalls at all.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left     = 0;
		hold_done     = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 260) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (results_seen >= 1300 && results_seen < 2100) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= 12);
			end
		end
	end

	// Hard stop if the handshakes hang.
	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

	function automatic sfcs_pkg::frame_in_t mk_frame(logic [15:0] rms, logic [15:0] flux,
		logic [15:0] per, logic [15:0] hi, logic [15:0] zcr, logic [15:0] cen,
		logic fpeak, logic signed [16:0] drms, logic [15:0] lo, logic [15:0] mid,
		logic valley);
		sfcs_pkg::frame_in_t f;
		f.rms_level       = rms;
		f.spectral_flux   = flux;
		f.periodicity     = per;
		f.high_band_level = hi;
		f.zero_cross_rate = zcr;
		f.centroid_level  = cen;
		f.flux_peak_flag  = fpeak;
		f.rms_delta       = drms;
		f.low_band_level  = lo;
		f.mid_band_level  = mid;
		f.rms_valley_flag = valley;
		return f;
	endfunction

	// Level mix: the edges, out-of-range values, the low-RMS region, all bits.
	function automatic logic [15:0] rand_level();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return sfcs_pkg::Q_ONE;
			2: return 16'($urandom_range(32769, 65535));
			3: return 16'($urandom_range(0, 6500));
			4: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic sfcs_pkg::frame_in_t rand_frame();
		sfcs_pkg::frame_in_t f;
		f.rms_level       = rand_level();
		f.spectral_flux   = rand_level();
		f.periodicity     = rand_level();
		f.high_band_level = rand_level();
		f.zero_cross_rate = rand_level();
		f.centroid_level  = rand_level();
		f.low_band_level  = rand_level();
		f.mid_band_level  = rand_level();
		f.flux_peak_flag  = 1'($urandom_range(0, 1));
		f.rms_valley_flag = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0: f.rms_delta = 17'($urandom);
			1: f.rms_delta = -17'sd32768;
			2: f.rms_delta = 17'sd32768;
			default: f.rms_delta = 17'(int'($urandom_range(0, 65536)) - 32768);
		endcase
		return f;
	endfunction

	// Offer one frame request; hold it until accepted, then note it.
	task automatic offer_frame(input sfcs_pkg::frame_in_t f, input bit may_idle);
		if (may_idle && $urandom_range(0, 99) < 12) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_axis_tdata  <= {7'd0, f.mid_band_level, f.low_band_level, f.rms_delta,
			f.centroid_level, f.zero_cross_rate, f.high_band_level, f.periodicity,
			f.spectral_flux, f.rms_level};
		s_axis_tuser  <= {f.rms_valley_flag, f.flux_peak_flag};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tracker.note_frame(f);
		@(negedge clk);
	endtask

	// Drop the input, drain every expected score, then allow the pipeline
	// latency to pass before touching the register.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.threshold = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] thr_plan[6];
		int          n_sent;

		tracker       = new();
		n_sent        = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under the reset threshold.
		offer_frame(mk_frame(0, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 0), 1'b1);
		offer_frame(mk_frame(sfcs_pkg::Q_ONE, sfcs_pkg::Q_ONE, sfcs_pkg::Q_ONE,
			sfcs_pkg::Q_ONE, sfcs_pkg::Q_ONE, sfcs_pkg::Q_ONE, 1, 17'sd32768,
			sfcs_pkg::Q_ONE, sfcs_pkg::Q_ONE, 1), 1'b1);
		// Out-of-range levels and delta saturate
		offer_frame(mk_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
			17'sh0FFFF, 16'hFFFF, 16'hFFFF, 1), 1'b1);
		offer_frame(mk_frame(16384, 16384, 16384, 16384, 16384, 16384, 0, 17'sh10000,
			16384, 16384, 0), 1'b1);
		offer_frame(mk_frame(8000, 20000, 0, 0, 0, 0, 1, -17'sd32768, 0, 0, 0), 1'b1);
		offer_frame(mk_frame(8000, 20000, 0, 0, 0, 0, 1, 17'sd32767, 0, 0, 0), 1'b1);
		// Speech score exactly at, and one below, the threshold
		offer_frame(mk_frame(1802, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 0), 1'b1);
		offer_frame(mk_frame(1801, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 0), 1'b1);
		// Silence bonus edge
		offer_frame(mk_frame(818, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 0), 1'b1);
		offer_frame(mk_frame(819, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 0), 1'b1);
		// Low-RMS smoothstep around and below its knee
		offer_frame(mk_frame(5897, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 1), 1'b1);
		offer_frame(mk_frame(5898, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 1), 1'b1);
		offer_frame(mk_frame(5899, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 1), 1'b1);
		offer_frame(mk_frame(2949, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 0), 1'b1);
		offer_frame(mk_frame(1, 0, 0, 0, 0, 0, 0, 17'sd0, 0, 0, 1), 1'b1);
		// Speech driven by flux alone, then by periodicity alone
		offer_frame(mk_frame(0, sfcs_pkg::Q_ONE, 0, 0, 0, 0, 1, 17'sd0, 0, 0, 0), 1'b1);
		offer_frame(mk_frame(0, 0, sfcs_pkg::Q_ONE, 0, 0, 0, 0, 17'sd0, 0, 0, 0), 1'b1);
		// Frication only; then large vowel factors with voicing
		offer_frame(mk_frame(0, 0, 0, sfcs_pkg::Q_ONE, sfcs_pkg::Q_ONE, sfcs_pkg::Q_ONE,
			0, 17'sd0, 0, 0, 0), 1'b1);
		offer_frame(mk_frame(sfcs_pkg::Q_ONE, 0, sfcs_pkg::Q_ONE, 0, 0, 0, 0, 17'sd0,
			sfcs_pkg::Q_ONE, sfcs_pkg::Q_ONE, 0), 1'b1);

		// Random phases over a spread of thresholds, extremes included; the
		// fourth one is above 1.0 and so is never reached.
		thr_plan = '{16'd0, sfcs_pkg::Q_ONE, 16'($urandom_range(0, 32768)), 16'hFFFF,
			16'($urandom), sfcs_pkg::THRESHOLD_RESET};
		foreach (thr_plan[p]) begin
			settle();
			write_threshold(thr_plan[p]);
			repeat (50) begin
				offer_frame(rand_frame(), !(n_sent >= 100 && n_sent < 160));
				n_sent++;
			end
		end

		settle();
		if (tracker.faults == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/sfcs_pkg.sv
rtl/sfcs_score_pipe.sv
rtl/speech_frame_class_scorer.sv
rtl/sfcs_checker.sv
bench/tb.sv
